@@ design/sdk_pkg.sv @@
// Shared constants, types and the arctangent table of the swerve drive kinematics block.
`default_nettype none
package sdk_pkg;

  localparam int WORD_W       = 16;
  localparam int ANG_W        = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CS_W         = 32;
  localparam int AZ_W         = 18;
  localparam int EW           = 19;
  localparam int AV_W         = 34;
  localparam int AV_SHIFT     = 12;
  localparam int RAD_W        = 2 * EW;
  localparam int SQRT_STEPS   = RAD_W / 2;
  localparam int ROOT_W       = SQRT_STEPS;
  localparam int REM_W        = ROOT_W + 3;
  localparam int DIV_W        = ROOT_W + 1;
  localparam int QUO_W        = 16;
  localparam int PROD_W       = 49;
  localparam int SUM_W        = PROD_W + 1;
  localparam int RP_W         = 33;
  localparam int NUM_WHEELS   = 4;

  localparam int SC_LAT    = CORDIC_STEPS + 1;
  localparam int WHEEL_LAT = SQRT_STEPS + 2;
  localparam int NORM_LAT  = QUO_W + 2;
  localparam int TOTAL_LAT = 4 + SC_LAT + WHEEL_LAT + NORM_LAT;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;
  localparam logic [ANG_W-1:0] ANG_HALF      = 16'h8000;
  localparam logic [ANG_W-1:0] ANG_QUARTER   = 16'h4000;
  localparam logic [ANG_W-1:0] ANG_WHEEL_OFS = 16'hC000;
  localparam logic [ROOT_W-1:0] SPEED_ONE = 19'd32768;
  localparam logic [ROOT_W-1:0] CRAB_CAP  = 19'd46341;

  // Mode codes. Code 3 is not assigned and runs as crab.
  localparam logic [1:0] MODE_UNSET  = 2'd0;
  localparam logic [1:0] MODE_SWERVE = 2'd1;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  localparam logic [1:0]        MODE_RESET  = 2'd1;
  localparam logic [WORD_W-1:0] RATIO_RESET = 16'd23170;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W:0]   y;
    logic signed [WORD_W-1:0] rot;
    logic                     swerve;
  } side_t;

  // atan(2^-i) in units of 2^-16 turn.
  function automatic logic [ANG_W-1:0] atan_val(input int unsigned i);
    logic [ANG_W-1:0] v;
    case (i)
      0:       v = 16'd8192;
      1:       v = 16'd4836;
      2:       v = 16'd2555;
      3:       v = 16'd1297;
      4:       v = 16'd651;
      5:       v = 16'd326;
      6:       v = 16'd163;
      7:       v = 16'd81;
      8:       v = 16'd41;
      9:       v = 16'd20;
      10:      v = 16'd10;
      11:      v = 16'd5;
      12:      v = 16'd3;
      13:      v = 16'd1;
      14:      v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/sdk_sincos.sv @@
// Pipelined rotation CORDIC that gives cosine and sine of the heading in Q30.
`default_nettype none
module sdk_sincos (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 vld_in,
  input  logic [sdk_pkg::ANG_W-1:0]            heading,
  input  sdk_pkg::side_t                       side_in,
  output logic                                 vld_out,
  output logic signed [sdk_pkg::CS_W-1:0]      cos_out,
  output logic signed [sdk_pkg::CS_W-1:0]      sin_out,
  output sdk_pkg::side_t                       side_out
);

  localparam int N = sdk_pkg::SC_LAT;

  logic [N-1:0]                       vld_r;
  logic signed [sdk_pkg::CS_W-1:0]    x_r [N];
  logic signed [sdk_pkg::CS_W-1:0]    y_r [N];
  logic signed [sdk_pkg::AZ_W-1:0]    a_r [N];
  logic                               flip_r [N];
  sdk_pkg::side_t                     side_r [N];

  logic signed [sdk_pkg::ANG_W-1:0] h_s;
  logic signed [sdk_pkg::ANG_W-1:0] h_red;
  logic                             flip;

  // Headings beyond a quarter turn are turned by a half turn first.
  always_comb begin
    h_s   = signed'(heading);
    flip  = (h_s > signed'(sdk_pkg::ANG_QUARTER)) || (h_s < -signed'(sdk_pkg::ANG_QUARTER));
    h_red = flip ? signed'(heading ^ sdk_pkg::ANG_HALF) : h_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= sdk_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    a_r[0]    <= sdk_pkg::AZ_W'(h_red);
    flip_r[0] <= flip;
    side_r[0] <= side_in;
  end

  for (genvar i = 0; i < sdk_pkg::CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [sdk_pkg::AZ_W-1:0] AT =
      signed'(sdk_pkg::AZ_W'(sdk_pkg::atan_val(i)));
    always_ff @(posedge clk) begin
      if (!a_r[i][sdk_pkg::AZ_W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - AT;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + AT;
      end
      flip_r[i+1] <= flip_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign vld_out  = vld_r[N-1];
  assign cos_out  = flip_r[N-1] ? -x_r[N-1] : x_r[N-1];
  assign sin_out  = flip_r[N-1] ? -y_r[N-1] : y_r[N-1];
  assign side_out = side_r[N-1];

endmodule
`default_nettype wire

@@ design/sdk_wheel.sv @@
// One wheel lane: pipelined floor square root and vectoring CORDIC for the steer angle.
`default_nettype none
module sdk_wheel (
  input  logic                             clk,
  input  logic signed [sdk_pkg::EW-1:0]    px,
  input  logic signed [sdk_pkg::EW-1:0]    py,
  output logic [sdk_pkg::ROOT_W-1:0]       spd,
  output logic [sdk_pkg::ANG_W-1:0]        ang
);

  localparam int SN      = sdk_pkg::SQRT_STEPS;
  localparam int CN      = sdk_pkg::CORDIC_STEPS;
  localparam int ANG_DLY = sdk_pkg::WHEEL_LAT - CN - 1;

  // Square root path.
  logic signed [sdk_pkg::RAD_W-1:0] sqx, sqy;
  logic [sdk_pkg::RAD_W-1:0]        sqx_r, sqy_r;
  logic [sdk_pkg::RAD_W-1:0]        rad_r  [SN+1];
  logic [sdk_pkg::REM_W-1:0]        rem_r  [SN+1];
  logic [sdk_pkg::ROOT_W-1:0]       root_r [SN+1];

  assign sqx = px * px;
  assign sqy = py * py;

  always_ff @(posedge clk) begin
    sqx_r     <= sqx;
    sqy_r     <= sqy;
    rad_r[0]  <= sqx_r + sqy_r;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar j = 0; j < SN; j++) begin : g_sqrt
    logic [sdk_pkg::REM_W-1:0] pre, trial;
    always_comb begin
      pre   = {rem_r[j][sdk_pkg::REM_W-3:0], rad_r[j][sdk_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_r[j], 2'b01};
    end
    always_ff @(posedge clk) begin
      rad_r[j+1] <= {rad_r[j][sdk_pkg::RAD_W-3:0], 2'b00};
      if (pre >= trial) begin
        rem_r[j+1]  <= pre - trial;
        root_r[j+1] <= {root_r[j][sdk_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[j+1]  <= pre;
        root_r[j+1] <= {root_r[j][sdk_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign spd = root_r[SN];

  // Angle path.
  logic signed [sdk_pkg::AV_W-1:0] ex, ey;
  logic signed [sdk_pkg::AV_W-1:0] ax_r [CN+1];
  logic signed [sdk_pkg::AV_W-1:0] ay_r [CN+1];
  logic [sdk_pkg::ANG_W-1:0]       az_r [CN+1];
  logic                            zero_r [CN+1];
  logic [sdk_pkg::ANG_W-1:0]       dly_r [ANG_DLY];

  assign ex = sdk_pkg::AV_W'(px) <<< sdk_pkg::AV_SHIFT;
  assign ey = sdk_pkg::AV_W'(py) <<< sdk_pkg::AV_SHIFT;

  // A vector in the left half plane is turned by a half turn first.
  always_ff @(posedge clk) begin
    zero_r[0] <= (px == '0) && (py == '0);
    if (px[sdk_pkg::EW-1]) begin
      ax_r[0] <= -ex;
      ay_r[0] <= -ey;
      az_r[0] <= sdk_pkg::ANG_HALF;
    end else begin
      ax_r[0] <= ex;
      ay_r[0] <= ey;
      az_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CN; i++) begin : g_vec
    localparam logic [sdk_pkg::ANG_W-1:0] AT = sdk_pkg::atan_val(i);
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (!ay_r[i][sdk_pkg::AV_W-1]) begin
        ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
        ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
        az_r[i+1] <= az_r[i] + AT;
      end else begin
        ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
        ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
        az_r[i+1] <= az_r[i] - AT;
      end
    end
  end

  // The zero vector has angle zero; the steer angle sits a quarter turn back.
  always_ff @(posedge clk) begin
    dly_r[0] <= (zero_r[CN] ? '0 : az_r[CN]) + sdk_pkg::ANG_WHEEL_OFS;
    for (int k = 1; k < ANG_DLY; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  assign ang = dly_r[ANG_DLY-1];

endmodule
`default_nettype wire

@@ design/sdk_norm.sv @@
// Speed normalization: largest speed, four pipelined dividers, crab saturation, output register.
`default_nettype none
module sdk_norm (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              vld_in,
  input  logic                                              swerve_in,
  input  logic [sdk_pkg::NUM_WHEELS-1:0][sdk_pkg::ROOT_W-1:0] spd_in,
  input  logic [sdk_pkg::NUM_WHEELS-1:0][sdk_pkg::ANG_W-1:0]  ang_in,
  output logic                                              vld_out,
  output logic [sdk_pkg::NUM_WHEELS-1:0][sdk_pkg::WORD_W-1:0] spd_out,
  output logic [sdk_pkg::NUM_WHEELS-1:0][sdk_pkg::ANG_W-1:0]  ang_out
);

  localparam int Q  = sdk_pkg::QUO_W;
  localparam int NW = sdk_pkg::NUM_WHEELS;

  logic [Q:0]                    vld_r;
  logic                          swerve_r [Q+1];
  logic                          scale_r  [Q+1];
  logic [sdk_pkg::ROOT_W-1:0]    mx_r     [Q+1];
  logic [sdk_pkg::DIV_W-1:0]     rem_r    [Q+1][NW];
  logic [Q-1:0]                  quo_r    [Q+1][NW];
  logic [sdk_pkg::ROOT_W-1:0]    spd_r    [Q+1][NW];
  logic [sdk_pkg::ANG_W-1:0]     ang_r    [Q+1][NW];

  logic                          vld_o_r;
  logic [NW-1:0][sdk_pkg::WORD_W-1:0] spd_o_r;
  logic [NW-1:0][sdk_pkg::ANG_W-1:0]  ang_o_r;

  logic [sdk_pkg::ROOT_W-1:0] mx;

  always_comb begin
    mx = spd_in[0];
    for (int l = 1; l < NW; l++) begin
      if (spd_in[l] > mx) mx = spd_in[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_o_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[Q-1:0], vld_in};
      vld_o_r <= vld_r[Q];
    end
  end

  always_ff @(posedge clk) begin
    swerve_r[0] <= swerve_in;
    scale_r[0]  <= swerve_in && (mx > sdk_pkg::SPEED_ONE);
    mx_r[0]     <= mx;
    for (int l = 0; l < NW; l++) begin
      rem_r[0][l] <= sdk_pkg::DIV_W'(spd_in[l]);
      quo_r[0][l] <= '0;
      spd_r[0][l] <= spd_in[l];
      ang_r[0][l] <= ang_in[l];
    end
  end

  // Restoring division of speed * 2^15 by the largest speed, one quotient bit a stage.
  // The first stage needs no shift since a speed never exceeds the largest.
  for (genvar s = 1; s <= Q; s++) begin : g_div
    logic [sdk_pkg::DIV_W-1:0] t [NW];
    always_comb begin
      for (int l = 0; l < NW; l++) begin
        t[l] = (s == 1) ? rem_r[s-1][l] : {rem_r[s-1][l][sdk_pkg::DIV_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      swerve_r[s] <= swerve_r[s-1];
      scale_r[s]  <= scale_r[s-1];
      mx_r[s]     <= mx_r[s-1];
      for (int l = 0; l < NW; l++) begin
        spd_r[s][l] <= spd_r[s-1][l];
        ang_r[s][l] <= ang_r[s-1][l];
        if (t[l] >= sdk_pkg::DIV_W'(mx_r[s-1])) begin
          rem_r[s][l] <= t[l] - sdk_pkg::DIV_W'(mx_r[s-1]);
          quo_r[s][l] <= {quo_r[s-1][l][Q-2:0], 1'b1};
        end else begin
          rem_r[s][l] <= t[l];
          quo_r[s][l] <= {quo_r[s-1][l][Q-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NW; l++) begin
      ang_o_r[l] <= ang_r[Q][l];
      if (scale_r[Q]) begin
        spd_o_r[l] <= sdk_pkg::WORD_W'(quo_r[Q][l]);
      end else if (swerve_r[Q] || (spd_r[Q][l] <= sdk_pkg::CRAB_CAP)) begin
        spd_o_r[l] <= sdk_pkg::WORD_W'(spd_r[Q][l]);
      end else begin
        spd_o_r[l] <= sdk_pkg::WORD_W'(sdk_pkg::CRAB_CAP);
      end
    end
  end

  assign vld_out = vld_o_r;
  assign spd_out = spd_o_r;
  assign ang_out = ang_o_r;

  a_swerve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[Q] && swerve_r[Q] |=>
      (sdk_pkg::ROOT_W'(spd_out[0]) <= sdk_pkg::SPEED_ONE) &&
      (sdk_pkg::ROOT_W'(spd_out[1]) <= sdk_pkg::SPEED_ONE) &&
      (sdk_pkg::ROOT_W'(spd_out[2]) <= sdk_pkg::SPEED_ONE) &&
      (sdk_pkg::ROOT_W'(spd_out[3]) <= sdk_pkg::SPEED_ONE))
    else $error("swerve speed above one");

  a_crab_equal: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[Q] && !swerve_r[Q] |=>
      (spd_out[0] == spd_out[1]) && (spd_out[1] == spd_out[2]) &&
      (spd_out[2] == spd_out[3]) && (ang_out[0] == ang_out[1]) &&
      (ang_out[1] == ang_out[2]) && (ang_out[2] == ang_out[3]))
    else $error("crab wheels disagree");

  a_scale_peak: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[Q] && scale_r[Q] |=>
      (sdk_pkg::ROOT_W'(spd_out[0]) == sdk_pkg::SPEED_ONE) ||
      (sdk_pkg::ROOT_W'(spd_out[1]) == sdk_pkg::SPEED_ONE) ||
      (sdk_pkg::ROOT_W'(spd_out[2]) == sdk_pkg::SPEED_ONE) ||
      (sdk_pkg::ROOT_W'(spd_out[3]) == sdk_pkg::SPEED_ONE))
    else $error("scaled speeds miss full speed");

endmodule
`default_nettype wire

@@ design/swerve_drive_kinematics_top.sv @@
// Top level of the swerve drive inverse kinematics pipeline with its register port.
`default_nettype none
// The block takes one drive command per clock: busy never rises, so a transfer happens at
// every edge where start is high. Each command in swerve or crab mode produces exactly one
// result, strobed by out_valid for one cycle; each command runs through the 16-stage heading
// CORDIC, the 19-stage square root and the 16-stage speed divider, back to back with four
// short arithmetic stages. Results leave in command order and cannot be held off, so the
// receiver must take every strobed result. In unset mode a command is taken and dropped.
// Registers (mode at 0x0, length ratio at 0x4, width ratio at 0x8) should be written only
// when no command is in flight.
module swerve_drive_kinematics_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sdk_pkg::WORD_W-1:0]    in_strafe,
  input  logic signed [sdk_pkg::WORD_W-1:0]    in_forward,
  input  logic signed [sdk_pkg::WORD_W-1:0]    in_rotation,
  input  logic [sdk_pkg::ANG_W-1:0]            in_heading,
  output logic                                 out_valid,
  output logic [sdk_pkg::WORD_W-1:0]           out_front_right_speed,
  output logic [sdk_pkg::WORD_W-1:0]           out_front_left_speed,
  output logic [sdk_pkg::WORD_W-1:0]           out_back_left_speed,
  output logic [sdk_pkg::WORD_W-1:0]           out_back_right_speed,
  output logic [sdk_pkg::ANG_W-1:0]            out_front_right_angle,
  output logic [sdk_pkg::ANG_W-1:0]            out_front_left_angle,
  output logic [sdk_pkg::ANG_W-1:0]            out_back_left_angle,
  output logic [sdk_pkg::ANG_W-1:0]            out_back_right_angle,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int NW = sdk_pkg::NUM_WHEELS;
  localparam logic signed [sdk_pkg::SUM_W-1:0] RND_Q30 = sdk_pkg::SUM_W'(2**29);
  localparam logic signed [sdk_pkg::RP_W-1:0]  RND_Q15 = sdk_pkg::RP_W'(2**14);

  // Configuration registers.
  logic [1:0]                  mode_r;
  logic [sdk_pkg::WORD_W-1:0]  len_r, wid_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sdk_pkg::MODE_RESET;
      len_r  <= sdk_pkg::RATIO_RESET;
      wid_r  <= sdk_pkg::RATIO_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sdk_pkg::REG_MODE:   mode_r <= pwdata[1:0];
        sdk_pkg::REG_LENGTH: len_r  <= pwdata[sdk_pkg::WORD_W-1:0];
        sdk_pkg::REG_WIDTH:  wid_r  <= pwdata[sdk_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sdk_pkg::REG_MODE:   prdata = 32'(mode_r);
      sdk_pkg::REG_LENGTH: prdata = 32'(len_r);
      sdk_pkg::REG_WIDTH:  prdata = 32'(wid_r);
      default:             prdata = '0;
    endcase
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Input stage: forward is negated so that positive y points along the field.
  logic                        p0_vld_r;
  sdk_pkg::side_t              p0_side_r;
  logic [sdk_pkg::ANG_W-1:0]   p0_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= start && !busy && (mode_r != sdk_pkg::MODE_UNSET);
    end
  end

  always_ff @(posedge clk) begin
    p0_side_r.x      <= in_strafe;
    p0_side_r.y      <= -((sdk_pkg::WORD_W+1)'(in_forward));
    p0_side_r.rot    <= in_rotation;
    p0_side_r.swerve <= (mode_r == sdk_pkg::MODE_SWERVE);
    p0_head_r        <= in_heading;
  end

  // Heading sine and cosine.
  logic                             cs_vld;
  logic signed [sdk_pkg::CS_W-1:0]  cs_c, cs_s;
  sdk_pkg::side_t                   cs_side;

  sdk_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (p0_vld_r),
    .heading  (p0_head_r),
    .side_in  (p0_side_r),
    .vld_out  (cs_vld),
    .cos_out  (cs_c),
    .sin_out  (cs_s),
    .side_out (cs_side)
  );

  // Products for the field rotation and the rotation terms.
  logic                               p1_vld_r, p1_swerve_r;
  logic signed [sdk_pkg::PROD_W-1:0]  xc_r, ys_r, xs_r, yc_r;
  logic signed [sdk_pkg::RP_W-1:0]    zlp_r, zwp_r;

  always_ff @(posedge clk) begin
    xc_r        <= sdk_pkg::PROD_W'(cs_side.x) * sdk_pkg::PROD_W'(cs_c);
    ys_r        <= sdk_pkg::PROD_W'(cs_side.y) * sdk_pkg::PROD_W'(cs_s);
    xs_r        <= sdk_pkg::PROD_W'(cs_side.x) * sdk_pkg::PROD_W'(cs_s);
    yc_r        <= sdk_pkg::PROD_W'(cs_side.y) * sdk_pkg::PROD_W'(cs_c);
    zlp_r       <= sdk_pkg::RP_W'(cs_side.rot) * sdk_pkg::RP_W'(signed'({1'b0, len_r}));
    zwp_r       <= sdk_pkg::RP_W'(cs_side.rot) * sdk_pkg::RP_W'(signed'({1'b0, wid_r}));
    p1_swerve_r <= cs_side.swerve;
  end

  // Rounded sums back to Q1.15 scale.
  logic signed [sdk_pkg::SUM_W-1:0] xr_sum, yr_sum;
  logic signed [sdk_pkg::RP_W-1:0]  zl_sum, zw_sum;
  logic                             p2_vld_r, p2_swerve_r;
  logic signed [sdk_pkg::EW-1:0]    xr_r, yr_r, zl_r, zw_r;

  assign xr_sum = sdk_pkg::SUM_W'(xc_r) - sdk_pkg::SUM_W'(ys_r) + RND_Q30;
  assign yr_sum = sdk_pkg::SUM_W'(xs_r) + sdk_pkg::SUM_W'(yc_r) + RND_Q30;
  assign zl_sum = zlp_r + RND_Q15;
  assign zw_sum = zwp_r + RND_Q15;

  always_ff @(posedge clk) begin
    xr_r        <= sdk_pkg::EW'(xr_sum >>> 30);
    yr_r        <= sdk_pkg::EW'(yr_sum >>> 30);
    zl_r        <= sdk_pkg::EW'(zl_sum >>> 15);
    zw_r        <= sdk_pkg::EW'(zw_sum >>> 15);
    p2_swerve_r <= p1_swerve_r;
  end

  // Wheel vectors: the four Ether pairs in swerve mode, the plain vector in crab mode.
  logic                                       p3_vld_r, p3_swerve_r;
  logic [NW-1:0][sdk_pkg::EW-1:0]             px_r, py_r;
  logic signed [sdk_pkg::EW-1:0]              ta, tb, tc, td;

  assign ta = xr_r - zl_r;
  assign tb = xr_r + zl_r;
  assign tc = yr_r - zw_r;
  assign td = yr_r + zw_r;

  always_ff @(posedge clk) begin
    p3_swerve_r <= p2_swerve_r;
    if (p2_swerve_r) begin
      px_r <= {ta, ta, tb, tb};
      py_r <= {tc, td, td, tc};
    end else begin
      px_r <= {xr_r, xr_r, xr_r, xr_r};
      py_r <= {yr_r, yr_r, yr_r, yr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cs_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // Wheel lanes, with the valid and mode bits running alongside.
  logic [NW-1:0][sdk_pkg::ROOT_W-1:0] w_spd;
  logic [NW-1:0][sdk_pkg::ANG_W-1:0]  w_ang;
  logic [sdk_pkg::WHEEL_LAT-1:0]      wv_r, ws_r;

  for (genvar w = 0; w < NW; w++) begin : g_wheel
    sdk_wheel u_wheel (
      .clk (clk),
      .px  (signed'(px_r[w])),
      .py  (signed'(py_r[w])),
      .spd (w_spd[w]),
      .ang (w_ang[w])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else begin
      wv_r <= {wv_r[sdk_pkg::WHEEL_LAT-2:0], p3_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    ws_r <= {ws_r[sdk_pkg::WHEEL_LAT-2:0], p3_swerve_r};
  end

  // Normalization and output register.
  logic [NW-1:0][sdk_pkg::WORD_W-1:0] n_spd;
  logic [NW-1:0][sdk_pkg::ANG_W-1:0]  n_ang;

  sdk_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_in    (wv_r[sdk_pkg::WHEEL_LAT-1]),
    .swerve_in (ws_r[sdk_pkg::WHEEL_LAT-1]),
    .spd_in    (w_spd),
    .ang_in    (w_ang),
    .vld_out   (out_valid),
    .spd_out   (n_spd),
    .ang_out   (n_ang)
  );

  assign out_front_right_speed = n_spd[0];
  assign out_front_left_speed  = n_spd[1];
  assign out_back_left_speed   = n_spd[2];
  assign out_back_right_speed  = n_spd[3];
  assign out_front_right_angle = n_ang[0];
  assign out_front_left_angle  = n_ang[1];
  assign out_back_left_angle   = n_ang[2];
  assign out_back_right_angle  = n_ang[3];

  // Every result traces back to a command taken in a mode that produces output.
  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (mode_r != sdk_pkg::MODE_UNSET), sdk_pkg::TOTAL_LAT))
    else $error("result without a matching command");

endmodule
`default_nettype wire

@@ sim/tb_swerve_drive_kinematics_top.sv @@
// Self-checking testbench of the swerve drive kinematics block: directed table, then random.
`timescale 1ns / 100ps
module tb_swerve_drive_kinematics_top;

  // Mode codes that the package leaves unnamed.
  localparam logic [1:0] MODE_CRAB  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Expected rows in the directed table: either worked out by the predictor,
  // or typed in as the all-still answer (zero speed, wheels at -90 degrees).
  localparam bit ROW_PREDICT = 1'b0;
  localparam bit ROW_STILL   = 1'b1;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = sdk_pkg::TOTAL_LAT + 8;

  // Arctangent steps in units of 2^-16 turn, shared by both CORDIC models.
  localparam int ATAN_STEP [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [15:0] strafe;
    logic signed [15:0] forward;
    logic signed [15:0] rotation;
    logic [15:0]        heading;
  } drive_cmd_t;

  // Index 0..3: front right, front left, back left, back right.
  typedef struct packed {
    logic [3:0][15:0] speed;
    logic [3:0][15:0] angle;
  } wheel_set_t;

  typedef struct packed {
    logic [1:0] mode;
    drive_cmd_t cmd;
    bit         kind;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  drive_cmd_t  cmd_q = '0;
  logic        out_valid;
  wheel_set_t  seen;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Typed answer of the directed row being sent, driven along with the command.
  logic        row_typed = 1'b0;
  wheel_set_t  row_want = '0;

  // The testbench's own copy of the registers.
  logic [1:0]  mode_reg = sdk_pkg::MODE_RESET;
  logic [15:0] length_reg = sdk_pkg::RATIO_RESET;
  logic [15:0] width_reg = sdk_pkg::RATIO_RESET;

  wheel_set_t  pending_wheels [$];
  bit          pending_typed [$];
  int          fail_count = 0;
  int          cmds_taken = 0;
  int          results_checked = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  swerve_drive_kinematics_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_strafe             (cmd_q.strafe),
    .in_forward            (cmd_q.forward),
    .in_rotation           (cmd_q.rotation),
    .in_heading            (cmd_q.heading),
    .out_valid             (out_valid),
    .out_front_right_speed (seen.speed[0]),
    .out_front_left_speed  (seen.speed[1]),
    .out_back_left_speed   (seen.speed[2]),
    .out_back_right_speed  (seen.speed[3]),
    .out_front_right_angle (seen.angle[0]),
    .out_front_left_angle  (seen.angle[1]),
    .out_back_left_angle   (seen.angle[2]),
    .out_back_right_angle  (seen.angle[3]),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // Sine and cosine of the heading in Q30 from a rotation CORDIC. Headings past
  // a quarter turn are folded by a half turn and the results negated.
  function automatic void heading_sin_cos(input logic [15:0] hd, output longint c,
                                          output longint s);
    longint a, x, y, xs, ys;
    bit flip;
    a = longint'($signed(hd));
    x = longint'(sdk_pkg::CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (a > 16384 || a < -16384) begin
      flip = 1'b1;
      a = longint'($signed(16'(a + 32768)));
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x = x - ys; y = y + xs; a = a - ATAN_STEP[i];
      end else begin
        x = x + ys; y = y - xs; a = a + ATAN_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Binary angle of (x, y) from a vectoring CORDIC, minus a quarter turn.
  function automatic logic [15:0] steer_angle(input longint px, input longint py);
    longint x, y, z, xs, ys;
    z = 0;
    if (px != 0 || py != 0) begin
      x = px * 4096;
      y = py * 4096;
      if (x < 0) begin
        x = -x; y = -y; z = 32768;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
        end
      end
    end
    return 16'(z - 16384);
  endfunction

  function automatic longint vec_length(input longint x, input longint y);
    longint unsigned n, r, b;
    n = x * x + y * y;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Wheel speeds and angles for one command under the current registers.
  // Returns 0 when the mode produces no result.
  function automatic bit wheel_targets(input drive_cmd_t cmd, output wheel_set_t w);
    longint x, y, rot, c, s, xr, yr, zl, zw, ea, eb, ec, ed, top;
    longint sp [4];
    longint px [4], py [4];
    w = '0;
    if (mode_reg == sdk_pkg::MODE_UNSET) return 1'b0;
    x = longint'(cmd.strafe);
    y = -longint'(cmd.forward);
    rot = longint'(cmd.rotation);
    heading_sin_cos(cmd.heading, c, s);
    xr = (x * c - y * s + (64'sd1 <<< 29)) >>> 30;
    yr = (x * s + y * c + (64'sd1 <<< 29)) >>> 30;
    if (mode_reg == sdk_pkg::MODE_SWERVE) begin
      zl = (rot * longint'(length_reg) + 16384) >>> 15;
      zw = (rot * longint'(width_reg) + 16384) >>> 15;
      ea = xr - zl; eb = xr + zl; ec = yr - zw; ed = yr + zw;
      px = '{eb, eb, ea, ea};
      py = '{ec, ed, ed, ec};
      top = 0;
      for (int k = 0; k < 4; k++) begin
        sp[k] = vec_length(px[k], py[k]);
        w.angle[k] = steer_angle(px[k], py[k]);
        if (sp[k] > top) top = sp[k];
      end
      for (int k = 0; k < 4; k++) begin
        if (top > 32768) sp[k] = sp[k] * 32768 / top;
        w.speed[k] = 16'(sp[k]);
      end
    end else begin
      top = vec_length(xr, yr);
      if (top > 46341) top = 46341;
      for (int k = 0; k < 4; k++) begin
        w.speed[k] = 16'(top);
        w.angle[k] = steer_angle(xr, yr);
      end
    end
    return 1'b1;
  endfunction

  // Every command transfer in a mode with a result pushes its expected wheel set, and
  // every strobed result is checked against the oldest one. Both read values from
  // before the edge. A typed directed row queues its answer in place of the prediction.
  always @(posedge clk) begin
    wheel_set_t w, want;
    bit typed;
    if (rst_n) begin
      if (start && !busy) begin
        cmds_taken++;
        if (wheel_targets(cmd_q, w)) begin
          if (row_typed) w = row_want;
          pending_wheels.push_back(w);
          pending_typed.push_back(row_typed);
        end
      end
      if (out_valid) begin
        if (pending_wheels.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, actual %h", $time, seen);
          fail_count++;
        end else begin
          want = pending_wheels.pop_front();
          typed = pending_typed.pop_front();
          results_checked++;
          for (int k = 0; k < 4; k++) begin
            if (seen.speed[k] !== want.speed[k]) begin
              $display("%0t: wheel %0d speed mismatch, expected %0d, actual %0d%s", $time, k,
                       want.speed[k], seen.speed[k], typed ? " (table row)" : "");
              fail_count++;
            end
            if (seen.angle[k] !== want.angle[k]) begin
              $display("%0t: wheel %0d angle mismatch, expected %0d, actual %0d%s", $time, k,
                       want.angle[k], seen.angle[k], typed ? " (table row)" : "");
              fail_count++;
            end
          end
        end
      end
    end
  end

  // The watchdog restarts on any transfer in either direction or on the register port.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("swerve_drive_kinematics_top test failed");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the data at the edge
  // that ends the access cycle since pready is always high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      sdk_pkg::REG_MODE:   mode_reg = val[1:0];
      sdk_pkg::REG_LENGTH: length_reg = val[15:0];
      sdk_pkg::REG_WIDTH:  width_reg = val[15:0];
      default:    ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Holds the command port idle until nothing is in flight. In unset mode
  // commands leave no expectation, so the full pipeline depth is waited out too.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raises start with the command, after a random number of idle cycles, and
  // returns at the edge where the transfer takes place.
  task automatic send_cmd(input drive_cmd_t cmd);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    cmd_q <= cmd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Headings favor the quarter-turn folds, where the sine and cosine change branch, and zero and half turn.
  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    logic [15:0] bounds [4];
    bounds = '{16'h4000, 16'hC000, 16'h8000, 16'h0000};
    c.strafe = pick_q15();
    c.forward = pick_q15();
    c.rotation = pick_q15();
    if ($urandom_range(5) == 0)
      c.heading = bounds[$urandom_range(3)] + 16'($urandom_range(2)) - 16'd1;
    else
      c.heading = 16'($urandom);
    return c;
  endfunction

  plan_row_t plan [] = '{
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, ROW_STILL},
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h0000, 16'h0000, 16'h8000}, ROW_STILL},
    '{sdk_pkg::MODE_SWERVE, '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h8000, 16'h0000, 16'h0000, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h8000, 16'h0000, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h0000, 16'h0000, 16'h8000, 16'h0000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h8000, 16'h8000, 16'h8000, 16'h8000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h4000, 16'hC000, 16'h1234, 16'h4000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h4000, 16'hC000, 16'h1234, 16'h4001}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h2000, 16'h3000, 16'hF000, 16'hC000}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'h2000, 16'h3000, 16'hF000, 16'hBFFF}, ROW_PREDICT},
    '{sdk_pkg::MODE_SWERVE, '{16'hFFFF, 16'h0001, 16'h0000, 16'h7FFF}, ROW_PREDICT},
    '{MODE_CRAB,            '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000}, ROW_STILL},
    '{MODE_CRAB,            '{16'h8000, 16'h8000, 16'h0000, 16'h0000}, ROW_PREDICT},
    '{MODE_CRAB,            '{16'h8000, 16'h7FFF, 16'h8000, 16'h2000}, ROW_PREDICT},
    '{MODE_CRAB,            '{16'h7FFF, 16'h8000, 16'h0000, 16'hE000}, ROW_PREDICT},
    '{MODE_SPARE,           '{16'h8000, 16'h8000, 16'h0000, 16'h1000}, ROW_PREDICT},
    '{sdk_pkg::MODE_UNSET,  '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1000}, ROW_PREDICT},
    '{sdk_pkg::MODE_UNSET,  '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, ROW_PREDICT}
  };

  initial begin
    drive_cmd_t c;
    wheel_set_t w;
    logic [1:0]  modes [9];
    logic [15:0] lens [9];
    logic [15:0] wids [9];
    modes = '{sdk_pkg::MODE_SWERVE, MODE_CRAB, sdk_pkg::MODE_SWERVE, sdk_pkg::MODE_SWERVE,
              sdk_pkg::MODE_SWERVE, sdk_pkg::MODE_UNSET, MODE_SPARE, sdk_pkg::MODE_SWERVE,
              MODE_CRAB};
    lens  = '{16'd23170, 16'd23170, 16'd0, 16'd32768, 16'd65535,
              16'd23170, 16'd1000, 16'($urandom), 16'd0};
    wids  = '{16'd23170, 16'd23170, 16'd32768, 16'd0, 16'd65535,
              16'd23170, 16'd1000, 16'($urandom), 16'd65535};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, at full rate but for a drain at each mode change. A typed row's
    // answer travels with its command; the monitor queues it in place of a prediction.
    foreach (plan[r]) begin
      if (plan[r].mode != mode_reg) begin
        wait_idle();
        write_reg(sdk_pkg::REG_MODE, {30'd0, plan[r].mode});
      end
      if (plan[r].kind == ROW_STILL) begin
        for (int k = 0; k < 4; k++) begin
          w.speed[k] = 16'd0;
          w.angle[k] = sdk_pkg::ANG_WHEEL_OFS;
        end
        row_want <= w;
        row_typed <= 1'b1;
      end
      send_cmd(plan[r].cmd);
      row_typed <= 1'b0;
    end

    // Random phases: each starts from an idle block with fresh registers.
    // Sender gaps run at 37 percent, then 54 percent, then none at all.
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_reg(sdk_pkg::REG_MODE, {30'd0, modes[p]});
      write_reg(sdk_pkg::REG_LENGTH, {16'd0, lens[p]});
      write_reg(sdk_pkg::REG_WIDTH, {16'd0, wids[p]});
      idle_pct = (p < 3) ? 37 : (p < 6) ? 54 : 0;
      for (int n = 0; n < 180; n++) begin
        c = random_cmd();
        send_cmd(c);
        // Once in a while the sender holds off until every result is home.
        if ($urandom_range(59) == 0) wait_idle();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d drive commands over 9 register settings (swerve, crab, spare and unset",
             cmds_taken);
    $display("modes, ratios from 0 to 65535); %0d wheel results were checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("swerve_drive_kinematics_top test passed");
    end else begin
      $display("swerve_drive_kinematics_top test failed");
    end
    $finish;
  end

endmodule
